[src/frame_crc16_checker_defines.svh]
// Assertion macros used by the checker's core module.
// Each macro expects clk and rst_n to be in scope.
`ifndef FRAME_CRC16_CHECKER_DEFINES_SVH
`define FRAME_CRC16_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/fcc_pkg.sv]
package fcc_pkg;

  // CRC-16, reflected form
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;

  // Frame layout: address, opcode, length, data..., CRC low, CRC high
  localparam logic [7:0]  HDR_LEN        = 8'd3;
  localparam logic [7:0]  MAX_DATA_LEN   = 8'd250;
  localparam logic [7:0]  DATA_LEN_RESET = 8'd3;

  // One received byte as held in the input register
  typedef struct packed {
    logic       restart;
    logic [7:0] byte_in;
  } fcc_item_t;

  // One frame result
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] computed_crc;
    logic [7:0]  opcode_out;
    logic [7:0]  target_addr;
  } fcc_result_t;

  // One byte through the CRC, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/frame_crc16_checker.sv]
// out_tvalid rises once the request with the CRC high byte has been accepted and has
// passed the input register, then the result register.
// Throughput: one byte per cycle; the input stalls only while a finished frame's result
// waits in a full result register. The CRC byte update is combinational.
// Reset (rst_n low, synchronous) empties both registers, rewinds the frame position,
// loads the CRC with 0xFFFF and sets the data length to 3.
module frame_crc16_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,  // data_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] target_addr, [15:8] opcode_out,
                                  // [31:16] computed_crc
  output logic        out_tuser   // [0] crc_ok
);
  import fcc_pkg::*;

  logic        item_valid;
  logic        item_take;
  fcc_item_t   item;
  logic        res_free;
  logic        res_load;
  fcc_result_t res;

  // Input register
  fcc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Frame walk and CRC
  fcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res)
  );

  // Result register
  fcc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_load),
    .res        (res),
    .res_free   (res_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[src/fcc_in_reg.sv]
module fcc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] byte_in
  input  logic              in_tuser,   // [0] restart
  input  logic              item_take,
  output logic              item_valid,
  output fcc_pkg::fcc_item_t item
);
  import fcc_pkg::*;

  logic      valid_r;
  fcc_item_t item_r;

  // Free when empty or when the held byte leaves this cycle
  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.byte_in <= in_tdata;
      item_r.restart <= in_tuser;
    end
  end

endmodule

[src/fcc_core.sv]
`include "frame_crc16_checker_defines.svh"

module fcc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                item_valid,
  input  fcc_pkg::fcc_item_t  item,
  output logic                item_take,
  input  logic                res_free,
  output logic                res_load,
  output fcc_pkg::fcc_result_t res
);
  import fcc_pkg::*;

  logic [7:0]  data_len_r;
  logic [7:0]  pos_r,   pos_nxt;
  logic [15:0] crc_r,   crc_nxt;
  logic [7:0]  addr_r,  addr_nxt;
  logic [7:0]  op_r,    op_nxt;
  logic [7:0]  rlow_r,  rlow_nxt;

  logic [7:0]  len;
  logic [7:0]  crc_lo_pos;
  logic [7:0]  crc_hi_pos;
  logic [7:0]  pos;
  logic [15:0] crc_base;
  logic        emit;

  // Length register, clamped so a frame stays within 255 bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_len_r <= DATA_LEN_RESET;
    end else if (cfg_we) begin
      data_len_r <= cfg_wdata;
    end
  end

  assign len        = (data_len_r > MAX_DATA_LEN) ? MAX_DATA_LEN : data_len_r;
  assign crc_lo_pos = len + HDR_LEN;
  assign crc_hi_pos = len + HDR_LEN + 8'd1;

  // Effective position and CRC seed for this byte
  assign pos      = item.restart ? 8'd0 : pos_r;
  assign crc_base = (pos == 8'd0) ? CRC_INIT : crc_r;
  assign emit     = item_valid && (pos == crc_hi_pos);

  // Byte leaves the input register unless its result cannot be placed
  assign item_take = item_valid && (!emit || res_free);
  assign res_load  = emit && res_free;

  // Result fields
  assign res.target_addr  = addr_r;
  assign res.opcode_out   = op_r;
  assign res.computed_crc = crc_r;
  assign res.crc_ok       = (rlow_r == crc_r[7:0]) && (item.byte_in == crc_r[15:8]);

  // Frame walk
  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    addr_nxt = addr_r;
    op_nxt   = op_r;
    rlow_nxt = rlow_r;
    if (item_take) begin
      if (pos == 8'd0) begin
        addr_nxt = item.byte_in;
      end
      if (pos == 8'd1) begin
        op_nxt = item.byte_in;
      end
      if (pos < crc_lo_pos) begin
        crc_nxt = crc16_byte(crc_base, item.byte_in);
        pos_nxt = pos + 8'd1;
      end else if (pos == crc_lo_pos) begin
        rlow_nxt = item.byte_in;
        pos_nxt  = pos + 8'd1;
      end else if (pos == crc_hi_pos) begin
        pos_nxt = 8'd0;
        crc_nxt = CRC_INIT;
      end else begin
        // past the end after a length change: hold until restart
        pos_nxt = pos;
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      crc_r  <= CRC_INIT;
      addr_r <= 8'd0;
      op_r   <= 8'd0;
      rlow_r <= 8'd0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      addr_r <= addr_nxt;
      op_r   <= op_nxt;
      rlow_r <= rlow_nxt;
    end
  end

  // Checks
  `FCC_ASSERT_NEXT(a_frame_end_rewinds, res_load, (pos_r == 8'd0) && (crc_r == CRC_INIT), "frame end did not rewind state")
  `FCC_ASSERT_NEXT(a_restart_takes_addr, item_take && item.restart, (pos_r == 8'd1) && (addr_r == $past(item.byte_in)), "restart byte not taken as address")
  `FCC_ASSERT_SAME(a_stall_only_on_result, item_valid && !item_take, emit && !res_free, "input held without a blocked result")

endmodule

[src/fcc_out_reg.sv]
module fcc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_load,
  input  fcc_pkg::fcc_result_t res,
  output logic                res_free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [7:0] target_addr, [15:8] opcode_out,
                                          // [31:16] computed_crc
  output logic                out_tuser   // [0] crc_ok
);
  import fcc_pkg::*;

  logic        valid_r;
  fcc_result_t res_r;

  // Slot is free when empty or drained this cycle
  assign res_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.computed_crc, res_r.opcode_out, res_r.target_addr};
  assign out_tuser  = res_r.crc_ok;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

endmodule
